// ===== src/vhe_pkg.sv =====
// Shared types, constants and a helper function of the voxel histogram equaliser.
`timescale 1ns / 1ps

package vhe_pkg;

    localparam int LEVELS     = 256;
    localparam int BIN_W      = $clog2(LEVELS);
    localparam int CNT_W      = 25;
    localparam int SPAN_W     = 9;
    localparam int LVL_W      = 8;
    localparam int PROD_W     = CNT_W + LVL_W;
    localparam int DIV_STEPS  = LVL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] MAX_VOXELS = CNT_W'(16777216);

    localparam logic FUNC_COUNT = 1'b0;
    localparam logic FUNC_REMAP = 1'b1;

    typedef logic [BIN_W-1:0]  t_bin;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [LVL_W-1:0]  t_lvl;
    typedef logic [PROD_W-1:0] t_prod;

    typedef struct packed {
        logic count_en;
        logic clear_en;
        t_bin rd_addr;
    } t_hist_ctl;

    function automatic t_cnt sat_inc(input t_cnt v);
        t_cnt res;
        if (v >= MAX_VOXELS) begin
            res = MAX_VOXELS;
        end else begin
            res = v + CNT_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== src/vhe_hist.sv =====
// Histogram memory with read-modify-write counting, valid bits and the total count.
`timescale 1ns / 1ps

module vhe_hist
    import vhe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_hist_ctl i_ctl,
    output t_cnt      o_bin_data,
    output t_cnt      o_total
);

    t_cnt             r_mem [LEVELS];
    logic [LEVELS-1:0] r_valid;
    t_cnt             r_rd_data;
    t_bin             r_rd_addr;
    logic             r_fwd_vld;
    t_bin             r_fwd_addr;
    t_cnt             r_fwd_data;
    t_cnt             r_total;
    t_cnt             bin_cur;
    t_cnt             n_bin;

    // The memory returns the old entry when it was written on the read edge,
    // so the value written in the previous cycle is forwarded.
    always_comb begin
        if (r_fwd_vld && (r_fwd_addr == r_rd_addr)) begin
            bin_cur = r_fwd_data;
        end else if (r_valid[r_rd_addr]) begin
            bin_cur = r_rd_data;
        end else begin
            bin_cur = '0;
        end
        n_bin = sat_inc(bin_cur);
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_ctl.rd_addr];
        r_rd_addr <= i_ctl.rd_addr;
        r_fwd_addr <= r_rd_addr;
        r_fwd_data <= n_bin;
        if (i_ctl.count_en) begin
            r_mem[r_rd_addr] <= n_bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_total   <= '0;
            r_fwd_vld <= 1'b0;
        end else begin
            r_fwd_vld <= i_ctl.count_en;
            if (i_ctl.clear_en) begin
                r_valid <= '0;
                r_total <= '0;
            end else if (i_ctl.count_en) begin
                r_valid[r_rd_addr] <= 1'b1;
                r_total            <= sat_inc(r_total);
            end
        end
    end

    assign o_bin_data = bin_cur;
    assign o_total    = r_total;

endmodule

// ===== src/vhe_div.sv =====
// Restoring divider that yields one quotient bit per cycle for the table build.
`timescale 1ns / 1ps

module vhe_div
    import vhe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_prod i_dividend,
    input  t_cnt  i_divisor,
    output logic  o_done,
    output t_lvl  o_quotient
);

    t_prod              r_rem;
    t_cnt               r_div;
    t_lvl               r_q;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;
    t_prod              shifted;
    logic               ge;

    // The quotient is known to fit in eight bits because the cumulative
    // count never exceeds the total.
    always_comb begin
        shifted = PROD_W'(r_div) << r_step;
        ge      = (r_rem >= shifted);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - shifted;
            end
            r_q <= {r_q[LVL_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== src/vhe_lut.sv =====
// Level table memory and the sequencer that rebuilds it from the histogram.
`timescale 1ns / 1ps

module vhe_lut
    import vhe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SPAN_W-1:0] i_span,
    input  t_cnt              i_bin_data,
    input  t_cnt              i_total,
    output logic              o_busy,
    output t_bin              o_hist_addr,
    input  t_bin              i_rd_addr,
    output t_lvl              o_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACC,
        S_MUL,
        S_DIV
    } t_state;

    t_state      r_state;
    t_bin        r_idx;
    t_cnt        r_cum;
    t_lvl        r_span_m1;
    logic        r_built;
    t_lvl        r_mem [LEVELS];
    t_lvl        r_rd_data;
    logic [CNT_W:0] cum_sum;
    t_cnt        n_cum;
    t_lvl        n_span_m1;
    logic        div_start;
    logic        div_done;
    t_lvl        div_q;
    logic        tbl_we;
    t_lvl        tbl_wdata;

    always_comb begin
        cum_sum = {1'b0, r_cum} + {1'b0, i_bin_data};
        if (cum_sum > {1'b0, i_total}) begin
            n_cum = i_total;
        end else begin
            n_cum = cum_sum[CNT_W-1:0];
        end
        // Out-of-range spans are clamped to the legal range of two to LEVELS.
        if (i_span < SPAN_W'(2)) begin
            n_span_m1 = LVL_W'(1);
        end else if (i_span > SPAN_W'(LEVELS)) begin
            n_span_m1 = LVL_W'(LEVELS - 1);
        end else begin
            n_span_m1 = LVL_W'(i_span - SPAN_W'(1));
        end
        div_start = (r_state == S_MUL);
        tbl_we    = (r_state == S_DIV) && div_done;
        tbl_wdata = (i_total == '0) ? '0 : div_q;
    end

    vhe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (PROD_W'(r_cum) * PROD_W'(r_span_m1)),
        .i_divisor  (i_total),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
        if (tbl_we) begin
            r_mem[r_idx] <= tbl_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_built   <= 1'b0;
            r_idx     <= '0;
            r_cum     <= '0;
            r_span_m1 <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_idx     <= '0;
                        r_cum     <= '0;
                        r_span_m1 <= n_span_m1;
                        r_state   <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_cum   <= n_cum;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_idx == BIN_W'(LEVELS - 1)) begin
                            r_built <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + BIN_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_hist_addr = r_idx;
    // Every build writes all entries, so one flag stands for the whole table.
    assign o_rd_data   = r_built ? r_rd_data : '0;

endmodule

// ===== src/voxel_histogram_equalizer_unit.sv =====
// Top level of the two-pass voxel histogram equaliser.
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// input     in         i_in_valid/o_in_stall  func, voxel, last
// output    out        o_out_valid/i_out_stall mapped_voxel, end_of_volume
// config    in         i_cfg_valid/o_cfg_ready level_span
//
// Count and remap voxels are taken one per cycle while input is not stalled; a remap
// result passes through the table memory's read register and then the output register.
// The voxel marked last in the counting pass starts a table build of 256
// entries (read, accumulate, multiply, eight divide steps and a write of the
// entry for each), during which input is stalled.
// Reset is synchronous; it empties the histogram and the table through valid flags.
// A stalled result holds the output register, and input stalls behind it.

module voxel_histogram_equalizer_unit
    import vhe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_in_func,
    input  logic [7:0]        i_in_voxel,
    input  logic              i_in_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_mapped_voxel,
    output logic              o_out_end_of_volume,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [SPAN_W-1:0] i_cfg_data
);

    logic              r_s1_vld;
    logic              r_s1_func;
    t_bin              r_s1_vox;
    logic              r_s1_last;
    logic              r_out_vld;
    t_lvl              r_out_map;
    logic              r_out_eov;
    logic [SPAN_W-1:0] r_span;
    logic              in_acc;
    logic              s1_adv;
    logic              build_start;
    logic              lut_busy;
    t_bin              lut_hist_addr;
    t_bin              tbl_rd_addr;
    t_lvl              tbl_rd_data;
    t_cnt              bin_data;
    t_cnt              total;
    t_hist_ctl         hist_ctl;

    always_comb begin
        s1_adv = r_s1_vld && ((r_s1_func == FUNC_COUNT) || !r_out_vld || !i_out_stall);
        build_start = r_s1_vld && (r_s1_func == FUNC_COUNT) && r_s1_last;
        o_in_stall  = lut_busy || (r_s1_vld && !s1_adv) || build_start;
        in_acc      = i_in_valid && !o_in_stall;
        // A remap voxel waiting on the output re-reads its own entry.
        tbl_rd_addr = (r_s1_vld && !s1_adv) ? r_s1_vox : i_in_voxel;
        hist_ctl.rd_addr  = lut_busy ? lut_hist_addr : i_in_voxel;
        hist_ctl.count_en = r_s1_vld && (r_s1_func == FUNC_COUNT);
        hist_ctl.clear_en = s1_adv && (r_s1_func == FUNC_REMAP) && r_s1_last;
    end

    vhe_hist u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (hist_ctl),
        .o_bin_data (bin_data),
        .o_total    (total)
    );

    vhe_lut u_lut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (build_start),
        .i_span      (r_span),
        .i_bin_data  (bin_data),
        .i_total     (total),
        .o_busy      (lut_busy),
        .o_hist_addr (lut_hist_addr),
        .i_rd_addr   (tbl_rd_addr),
        .o_rd_data   (tbl_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func <= i_in_func;
            r_s1_vox  <= i_in_voxel;
            r_s1_last <= i_in_last;
        end
        if (s1_adv && (r_s1_func == FUNC_REMAP)) begin
            r_out_map <= tbl_rd_data;
            r_out_eov <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_span    <= SPAN_W'(LEVELS);
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv && (r_s1_func == FUNC_REMAP)) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_span <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready         = 1'b1;
    assign o_out_valid         = r_out_vld;
    assign o_out_mapped_voxel  = r_out_map;
    assign o_out_end_of_volume = r_out_eov;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the voxel histogram equaliser with a queue-fed driver and a monitor.
`timescale 1ns / 1ps

module testbench;

    import vhe_pkg::*;

    localparam int IDLE_PCT       = 29;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int QUIET_CYCLES   = 3500;
    localparam int TAIL_CYCLES    = 3500;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLDOFF_AT     = 8;
    localparam int HOLDOFF_CYCLES = 400;

    typedef enum logic [1:0] {FEED_VOXEL, FEED_SPAN, FEED_DRAIN} t_feed_kind;
    typedef enum logic [2:0] {DRV_SEND, DRV_SETTLE, DRV_QUIET, DRV_CFG, DRV_DONE} t_drv_state;

    typedef struct packed {
        t_feed_kind        kind;
        logic              func;
        logic [7:0]        voxel;
        logic              last;
        logic [SPAN_W-1:0] span;
    } t_feed_entry;

    typedef struct packed {
        t_lvl mapped;
        logic eov;
    } t_remap_result;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic              in_func   = 1'b0;
    logic [7:0]        in_voxel  = 8'h00;
    logic              in_last   = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        out_mapped;
    logic              out_eov;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SPAN_W-1:0] cfg_data  = '0;

    // Pending stimulus and the predicted remap results still to come.
    t_feed_entry   voxel_feed_q[$];
    t_remap_result expected_remap_q[$];

    // Predicted state of the block.
    t_cnt              bin_tally [LEVELS] = '{default: '0};
    t_cnt              voxel_total        = '0;
    t_lvl              level_lut [LEVELS] = '{default: '0};
    logic [SPAN_W-1:0] span_setting       = SPAN_W'(LEVELS);

    logic       in_took       = 1'b0;
    logic       cfg_took      = 1'b0;
    logic       feed_done     = 1'b0;
    t_drv_state drv_state     = DRV_SEND;
    int         quiet_left    = 0;
    int         accepted_cnt  = 0;
    int         results_seen  = 0;
    int         fail_count    = 0;
    int         cycle_count   = 0;
    int         tail_count    = 0;
    int         holdoff_left  = 0;
    logic       holdoff_done  = 1'b0;
    logic       tx_calm;
    logic       rx_calm;

    assign tx_calm = (accepted_cnt >= 600) && (accepted_cnt < 900);
    assign rx_calm = (results_seen >= 300) && (results_seen < 500);

    voxel_histogram_equalizer_unit u_top (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_in_func           (in_func),
        .i_in_voxel          (in_voxel),
        .i_in_last           (in_last),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_out_mapped_voxel  (out_mapped),
        .o_out_end_of_volume (out_eov),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_data          (cfg_data)
    );

    always #6 clk = ~clk;

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic t_cnt saturating_bump(input t_cnt c);
        return (c >= MAX_VOXELS) ? MAX_VOXELS : c + 1'b1;
    endfunction

    task automatic rebuild_level_table();
        longint unsigned levels;
        longint unsigned running;
        levels  = span_setting;
        running = 0;
        if (levels < 2) levels = 2;
        if (levels > LEVELS) levels = LEVELS;
        for (int b = 0; b < LEVELS; b++) begin
            running += bin_tally[b];
            // A saturated bin may push the running sum past the saturated total.
            if (running > voxel_total) running = voxel_total;
            if (voxel_total == 0) begin
                level_lut[b] = '0;
            end else begin
                level_lut[b] = t_lvl'((running * (levels - 1)) / voxel_total);
            end
        end
    endtask

    task automatic absorb_voxel(input logic f, input t_bin v, input logic l);
        t_remap_result r;
        if (f == FUNC_COUNT) begin
            bin_tally[v] = saturating_bump(bin_tally[v]);
            voxel_total  = saturating_bump(voxel_total);
            if (l) rebuild_level_table();
        end else begin
            r.mapped = level_lut[v];
            r.eov    = l;
            expected_remap_q.push_back(r);
            if (l) begin
                foreach (bin_tally[b]) bin_tally[b] = '0;
                voxel_total = '0;
            end
        end
    endtask

    function automatic t_feed_entry voxel_entry(input logic f, input logic [7:0] v,
                                                input logic l);
        t_feed_entry e;
        e       = '0;
        e.kind  = FEED_VOXEL;
        e.func  = f;
        e.voxel = v;
        e.last  = l;
        return e;
    endfunction

    function automatic t_feed_entry control_entry(input t_feed_kind k,
                                                  input logic [SPAN_W-1:0] s);
        t_feed_entry e;
        e      = '0;
        e.kind = k;
        e.span = s;
        return e;
    endfunction

    function automatic logic [SPAN_W-1:0] span_for_phase(input int p);
        case (p)
            0:       return SPAN_W'(2);
            1:       return SPAN_W'(0);
            2:       return SPAN_W'(511);
            3:       return SPAN_W'(1);
            4:       return SPAN_W'(256);
            5:       return SPAN_W'(257);
            6:       return SPAN_W'(3);
            7:       return SPAN_W'(255);
            default: return SPAN_W'($urandom_range(0, 511));
        endcase
    endfunction

    // Voxels are drawn uniformly, from a narrow band, or from two values only,
    // so that the histograms come out flat, peaked and bimodal.
    function automatic logic [7:0] draw_voxel(input int mode, input logic [7:0] base,
                                              input logic [7:0] alt, input int width);
        case (mode)
            0:       return 8'($urandom);
            1:       return base + 8'($urandom_range(0, width));
            default: return $urandom_range(0, 1) ? base : alt;
        endcase
    endfunction

    initial begin : build_stimulus
        int         produced;
        int         n;
        int         mode;
        int         width;
        int         phase;
        logic [7:0] base;
        logic [7:0] alt;
        logic [7:0] directed_count [6];
        logic [7:0] directed_remap [10];
        directed_count = '{8'h00, 8'hFF, 8'hFF, 8'h80, 8'h7F, 8'h33};
        directed_remap = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h33, 8'h01, 8'hFE, 8'h40,
                           8'hC0, 8'h20};

        // Remapping before any table has been built reads the cleared table.
        voxel_feed_q.push_back(voxel_entry(FUNC_REMAP, 8'h00, 1'b0));
        voxel_feed_q.push_back(voxel_entry(FUNC_REMAP, 8'hFF, 1'b0));
        voxel_feed_q.push_back(voxel_entry(FUNC_REMAP, 8'h5A, 1'b1));
        voxel_feed_q.push_back(voxel_entry(FUNC_REMAP, 8'hA5, 1'b0));
        foreach (directed_count[k]) begin
            voxel_feed_q.push_back(voxel_entry(FUNC_COUNT, directed_count[k], k == 5));
        end
        foreach (directed_remap[k]) begin
            voxel_feed_q.push_back(voxel_entry(FUNC_REMAP, directed_remap[k], k == 9));
        end
        voxel_feed_q.push_back(control_entry(FEED_DRAIN, '0));

        produced = 0;
        phase    = 0;
        while (produced < RANDOM_ITEMS) begin
            if (produced >= phase * 120) begin
                voxel_feed_q.push_back(control_entry(FEED_SPAN, span_for_phase(phase)));
                phase++;
            end
            if ($urandom_range(0, 99) < 82) begin
                mode  = $urandom_range(0, 2);
                base  = 8'($urandom);
                alt   = 8'($urandom);
                width = $urandom_range(0, 15);
                n     = $urandom_range(1, 40);
                // A pass now and then lacks its closing voxel.
                for (int k = 0; k < n; k++) begin
                    voxel_feed_q.push_back(voxel_entry(FUNC_COUNT,
                        draw_voxel(mode, base, alt, width),
                        (k == n - 1) && ($urandom_range(0, 99) >= 8)));
                end
                produced += n;
                n = $urandom_range(1, 40);
                for (int k = 0; k < n; k++) begin
                    voxel_feed_q.push_back(voxel_entry(FUNC_REMAP,
                        $urandom_range(0, 1) ? draw_voxel(mode, base, alt, width)
                                             : 8'($urandom),
                        (k == n - 1) && ($urandom_range(0, 99) >= 8)));
                end
                produced += n;
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    voxel_feed_q.push_back(voxel_entry(1'($urandom), 8'($urandom),
                                                       $urandom_range(0, 99) < 20));
                end
                produced += n;
            end
            if ($urandom_range(0, 99) < 6) begin
                voxel_feed_q.push_back(control_entry(FEED_DRAIN, '0));
            end
        end
    end

    always @(negedge clk) begin : voxel_driver
        t_feed_entry head;
        logic        nxt_valid;
        logic        nxt_cfg_valid;
        nxt_valid     = in_valid && !in_took;
        nxt_cfg_valid = cfg_valid && !cfg_took;
        if (rst_n) begin
            case (drv_state)
                DRV_SEND: begin
                    if (!nxt_valid) begin
                        if (voxel_feed_q.size() == 0) begin
                            drv_state <= DRV_DONE;
                            feed_done <= 1'b1;
                        end else if (voxel_feed_q[0].kind != FEED_VOXEL) begin
                            drv_state <= DRV_SETTLE;
                        end else if (tx_calm || $urandom_range(0, 99) >= IDLE_PCT) begin
                            head = voxel_feed_q.pop_front();
                            in_func  <= head.func;
                            in_voxel <= head.voxel;
                            in_last  <= head.last;
                            nxt_valid = 1'b1;
                        end
                    end
                end
                DRV_SETTLE: begin
                    if (expected_remap_q.size() == 0) begin
                        if (voxel_feed_q[0].kind == FEED_SPAN) begin
                            // A table build may still run with no result pending.
                            quiet_left <= QUIET_CYCLES;
                            drv_state  <= DRV_QUIET;
                        end else begin
                            void'(voxel_feed_q.pop_front());
                            drv_state <= DRV_SEND;
                        end
                    end
                end
                DRV_QUIET: begin
                    if (quiet_left == 0) begin
                        cfg_data      <= voxel_feed_q[0].span;
                        nxt_cfg_valid = 1'b1;
                        drv_state     <= DRV_CFG;
                    end else begin
                        quiet_left <= quiet_left - 1;
                    end
                end
                DRV_CFG: begin
                    if (!nxt_cfg_valid) begin
                        void'(voxel_feed_q.pop_front());
                        drv_state <= DRV_SEND;
                    end
                end
                default: ;
            endcase
        end
        in_valid  <= nxt_valid;
        cfg_valid <= nxt_cfg_valid;
    end

    always @(negedge clk) begin : result_sink
        if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            out_stall <= 1'b1;
            holdoff_left--;
        end else begin
            out_stall <= !rx_calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk) begin : remap_monitor
        t_remap_result want;
        in_took  = in_valid && (in_stall === 1'b0);
        cfg_took = cfg_valid && (cfg_ready === 1'b1);
        if (cfg_took) span_setting = cfg_data;
        if (in_took) begin
            accepted_cnt++;
            absorb_voxel(in_func, in_voxel, in_last);
        end
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            results_seen++;
            if (expected_remap_q.size() == 0) begin
                $display("%0t: unexpected result transfer, mapped_voxel %0d end_of_volume %0b",
                         $time, out_mapped, out_eov);
                fail_count++;
            end else begin
                want = expected_remap_q.pop_front();
                if (out_mapped !== want.mapped) begin
                    $display("%0t: mapped_voxel mismatch, expected %0d, actual %0d",
                             $time, want.mapped, out_mapped);
                    fail_count++;
                end
                if (out_eov !== want.eov) begin
                    $display("%0t: end_of_volume mismatch, expected %0b, actual %0b",
                             $time, want.eov, out_eov);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge clk) begin : run_control
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_remap_q.size());
            $display("Simulation FAILED");
            $finish;
        end else if (feed_done && expected_remap_q.size() == 0) begin
            if (tail_count >= TAIL_CYCLES) begin
                if (fail_count == 0) begin
                    $display("Simulation PASSED");
                end else begin
                    $display("Simulation FAILED");
                end
                $finish;
            end else begin
                tail_count++;
            end
        end
    end

endmodule
